>>> src/iiea_pkg.sv
package iiea_pkg;

    // Fixed field widths of the request and result
    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = 7;

    // Request codes
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_ERASE  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_ERASE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [WORD_W-1:0]  word;
    } cell_ctl_t;

endpackage

>>> src/iiea_cell.sv
module iiea_cell
    import iiea_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [CMP_W-1:0]  pos,
    input  logic [CMP_W-1:0]  cnt,
    input  logic [WORD_W-1:0] prev_data,
    input  logic [WORD_W-1:0] next_data,
    output logic [WORD_W-1:0] data,
    output logic [WORD_W-1:0] rd_part
);

    localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] NXT_IDX = CMP_W'(INDEX + 1);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // Per-cell update: take new word, left neighbor, right neighbor, or hold
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_APPEND:
            begin
                if (MY_IDX == cnt)
                begin
                    data_next = ctl.word;
                end
            end
            CELL_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = ctl.word;
                end
                else if ((MY_IDX > pos) && (MY_IDX <= cnt))
                begin
                    data_next = prev_data;
                end
            end
            CELL_ERASE:
            begin
                if ((MY_IDX >= pos) && (NXT_IDX < cnt))
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Word storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Read tap: only the addressed cell drives its word onto the OR bus
    assign rd_part = (MY_IDX == pos) ? data_reg : '0;

endmodule

>>> src/iiea_ctrl.sv
module iiea_ctrl
    import iiea_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int CW    = 7,
    parameter int CMP_W = 7
)
(
    input  logic              accept,
    input  logic [1:0]        req_type,
    input  logic [POS_W-1:0]  position,
    input  logic [WORD_W-1:0] value,
    input  logic [CW-1:0]     count_cur,
    output logic [CMP_W-1:0]  pos_cmp,
    output logic [CMP_W-1:0]  cnt_cmp,
    output cell_ctl_t         ctl,
    output logic [CW-1:0]     count_next,
    output status_t           status,
    output logic              rd_en
);

    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic full;
    logic in_range;

    assign pos_cmp  = CMP_W'(position);
    assign cnt_cmp  = CMP_W'(count_cur);
    assign full     = (count_cur == FULL_CNT);
    assign in_range = (pos_cmp < cnt_cmp);

    // Request decode: range check first, then full check (append checks only full)
    always_comb
    begin
        ctl.op     = CELL_HOLD;
        ctl.word   = value;
        count_next = count_cur;
        status     = ST_OK;
        rd_en      = 1'b0;
        case (req_type)
            REQ_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.op     = CELL_APPEND;
                    count_next = count_cur + CW'(1);
                end
            end
            REQ_INSERT:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctl.op     = CELL_INSERT;
                    count_next = count_cur + CW'(1);
                end
            end
            REQ_ERASE:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctl.op     = CELL_ERASE;
                    count_next = count_cur - CW'(1);
                end
            end
            REQ_READ:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        // Nothing moves unless the request is actually transferred
        if (!accept)
        begin
            ctl.op     = CELL_HOLD;
            count_next = count_cur;
        end
    end

endmodule

>>> src/indexed_insert_erase_array_unit.sv
// Channel | Signals                             | Direction
// --------+-------------------------------------+----------
// request | in_valid, in_ready, req_type,       | in
//         | position, value                     |
// result  | out_valid, out_ready, status,       | out
//         | read_value, count                   |
//
// Each request completes at the edge that accepts it: the row of DEPTH cells shifts all
// later words in the same clock, and the result lands in an output register.
// Sustained rate is one request per cycle while the result side keeps up.
// A new request is taken while the held result is transferred in the same cycle.
// Reset clears the element count and the result valid; stored words are not cleared.
// When out_ready is low, the held result waits and in_ready drops.
module indexed_insert_erase_array_unit
    import iiea_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [POS_W-1:0]  position,
    input  logic [WORD_W-1:0] value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [WORD_W-1:0] read_value,
    output logic [CNT_W-1:0]  count
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic                in_xfer;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    status_t             status_reg;
    logic [WORD_W-1:0]   rdata_reg;
    logic [CNT_W-1:0]    count_out_reg;

    cell_ctl_t           ctl;
    logic [CMP_W-1:0]    pos_cmp;
    logic [CMP_W-1:0]    cnt_cmp;
    status_t             status_dec;
    logic                rd_en;
    logic [WORD_W-1:0]   rd_bus;

    logic [WORD_W-1:0]   cell_data [DEPTH];
    logic [WORD_W-1:0]   cell_rd   [DEPTH];

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Request decode and count update
    iiea_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .CMP_W (CMP_W)
    ) u_ctrl (
        .accept     (in_xfer),
        .req_type   (req_type),
        .position   (position),
        .value      (value),
        .count_cur  (count_reg),
        .pos_cmp    (pos_cmp),
        .cnt_cmp    (cnt_cmp),
        .ctl        (ctl),
        .count_next (count_next),
        .status     (status_dec),
        .rd_en      (rd_en)
    );

    // Row of cells, each linked to its neighbors (tied to zero at the two ends)
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;
        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_mid_p
            assign prev_w = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_mid_n
            assign next_w = cell_data[i+1];
        end
        iiea_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .pos       (pos_cmp),
            .cnt       (cnt_cmp),
            .prev_data (prev_w),
            .next_data (next_w),
            .data      (cell_data[i]),
            .rd_part   (cell_rd[i])
        );
    end

    // OR bus over the cell read taps (at most one tap is nonzero)
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg    <= status_dec;
            rdata_reg     <= rd_en ? rd_bus : '0;
            count_out_reg <= CNT_W'(count_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = rdata_reg;
    assign count      = count_out_reg;

    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // A successful append grows the count by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && req_type == REQ_APPEND && count_reg != CW'(DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not grow count");

    // A full status is only reported while the store is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with room left");

    // A range error leaves the count unchanged
    a_range_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && status_dec == ST_RANGE) |=> $stable(count_reg))
        else $error("range error changed count");

endmodule

>>> tb/sv/indexed_insert_erase_array_unit_test.sv
`timescale 1ns / 1ps

module indexed_insert_erase_array_unit_test;
    import iiea_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int IDLE_PCT   = 18;
    localparam int RAND_ITEMS = 1300;

    // Expected result of one request
    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  read_value;
        logic [CNT_W-1:0]   count;
    } result_t;

    // One row of the directed script; fixed rows carry the typed-in result
    typedef struct packed {
        req_t               kind;
        logic [POS_W-1:0]   pos;
        logic [WORD_W-1:0]  word;
        bit                 fixed;
        status_t            st;
        logic [WORD_W-1:0]  rd;
        logic [CNT_W-1:0]   cnt;
    } script_row_t;

    // The store is filled to capacity just before this row
    localparam int FILL_ROW = 18;
    localparam int N_ROWS   = 26;

    localparam script_row_t SCRIPT [0:N_ROWS-1] = '{
        '{REQ_READ,   6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{REQ_ERASE,  6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{REQ_INSERT, 6'd0,  32'h0000_0005, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{REQ_APPEND, 6'd0,  32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0, 7'd1},
        '{REQ_APPEND, 6'd63, 32'h8000_0000, 1'b1, ST_OK,    32'h0, 7'd2},
        '{REQ_READ,   6'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,    32'h7FFF_FFFF, 7'd2},
        '{REQ_READ,   6'd1,  32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000, 7'd2},
        '{REQ_INSERT, 6'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 7'd3},
        '{REQ_INSERT, 6'd2,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd2,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd3,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd4,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd4},
        '{REQ_ERASE,  6'd0,  32'h0000_0000, 1'b1, ST_OK,    32'h0, 7'd3},
        '{REQ_ERASE,  6'd2,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_ERASE,  6'd1,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_ERASE,  6'd0,  32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd0},
        '{REQ_APPEND, 6'd0,  32'h1234_5678, 1'b1, ST_FULL,  32'h0, 7'd64},
        '{REQ_INSERT, 6'd0,  32'h0BAD_F00D, 1'b1, ST_FULL,  32'h0, 7'd64},
        '{REQ_INSERT, 6'd63, 32'h5555_AAAA, 1'b1, ST_FULL,  32'h0, 7'd64},
        '{REQ_READ,   6'd63, 32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_ERASE,  6'd63, 32'h0000_0000, 1'b1, ST_OK,    32'h0, 7'd63},
        '{REQ_READ,   6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0, 7'd63},
        '{REQ_INSERT, 6'd62, 32'hA5A5_A5A5, 1'b0, ST_OK,    32'h0, 7'd0},
        '{REQ_READ,   6'd62, 32'h0000_0000, 1'b0, ST_OK,    32'h0, 7'd0}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type   = REQ_APPEND;
    logic [POS_W-1:0]  position   = '0;
    logic [WORD_W-1:0] value      = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [1:0]        status;
    logic [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]  count;

    // Shadow copy of the array and its element count
    logic [WORD_W-1:0] shadow_words [0:CAPACITY-1];
    int unsigned       shadow_count = 0;
    result_t           pending_results [$];

    bit calm_stretch = 1'b0;
    int mismatches   = 0;
    int checked      = 0;
    int op_seen      [4];
    int status_seen  [3];
    int peak_count   = 0;

    indexed_insert_erase_array_unit #(.DEPTH(CAPACITY)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    always #1 clk = ~clk;

    // Apply one request to the shadow array and return its result
    function automatic result_t predict_result(input req_t kind,
                                               input logic [POS_W-1:0] pos,
                                               input logic [WORD_W-1:0] word);
        result_t r;
        r.status     = ST_OK;
        r.read_value = '0;
        if (kind == REQ_APPEND)
        begin
            if (shadow_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                shadow_words[shadow_count] = word;
                shadow_count++;
            end
        end
        else if (pos >= shadow_count)
            r.status = ST_RANGE;
        else if (kind == REQ_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (int i = shadow_count; i > pos; i--)
                    shadow_words[i] = shadow_words[i-1];
                shadow_words[pos] = word;
                shadow_count++;
            end
        end
        else if (kind == REQ_ERASE)
        begin
            for (int i = pos; i + 1 < shadow_count; i++)
                shadow_words[i] = shadow_words[i+1];
            shadow_count--;
        end
        else
            r.read_value = shadow_words[pos];
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Drive one request from a falling edge and hold it until the transfer
    task automatic send_request(input req_t kind, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] word,
                                input bit use_fixed, input result_t fixed);
        result_t predicted;
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        position <= pos;
        value    <= word;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_result(kind, pos, word);
        pending_results.insert(pending_results.size(), use_fixed ? fixed : predicted);
        op_seen[kind]++;
        status_seen[predicted.status]++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        @(negedge clk);
    endtask

    // Random word, with the extremes showing up now and then
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Hold off the sender until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result side stalls at random except in the calm stretch
    always @(negedge clk)
        out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none expected: st=%0d rd=%h cnt=%0d",
                                          status, read_value, count));
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              read_value, want.read_value));
                if (count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              count, want.count));
            end
        end
    end

    // Stimulus: directed script, then random phases biased to grow, to shrink or evenly mixed
    initial
    begin
        result_t          fixed;
        result_t          none;
        req_t             kind;
        logic [POS_W-1:0] pos;
        int               seg_left;
        int               mode;
        int               roll;

        none = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (i == FILL_ROW)
            begin
                while (shadow_count < CAPACITY)
                    send_request(REQ_APPEND, 6'($urandom_range(63)), pick_word(), 1'b0, none);
            end
            fixed.status     = SCRIPT[i].st;
            fixed.read_value = SCRIPT[i].rd;
            fixed.count      = SCRIPT[i].cnt;
            send_request(SCRIPT[i].kind, SCRIPT[i].pos, SCRIPT[i].word,
                         SCRIPT[i].fixed, fixed);
        end

        seg_left = 0;
        mode     = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 300 || n == 950)
                drain_results();
            calm_stretch = (n >= 500 && n < 800);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(120, 40);
                mode     = $urandom_range(2);
            end
            seg_left--;

            // 0 grow, 1 shrink, 2 even mix
            roll = $urandom_range(99);
            case (mode)
                0:       kind = roll < 45 ? REQ_APPEND : roll < 75 ? REQ_INSERT :
                                roll < 85 ? REQ_ERASE  : REQ_READ;
                1:       kind = roll < 10 ? REQ_APPEND : roll < 20 ? REQ_INSERT :
                                roll < 70 ? REQ_ERASE  : REQ_READ;
                default: kind = req_t'(roll % 4);
            endcase

            if (shadow_count > 0 && $urandom_range(99) < 85)
                pos = POS_W'($urandom_range(shadow_count - 1));
            else
                pos = POS_W'($urandom_range(63));
            send_request(kind, pos, pick_word(), 1'b0, none);
        end
        calm_stretch = 1'b0;

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d appends, %0d inserts, %0d erases, %0d reads; %0d results checked",
                 op_seen[REQ_APPEND], op_seen[REQ_INSERT], op_seen[REQ_ERASE],
                 op_seen[REQ_READ], checked);
        $display("Statuses: %0d ok, %0d out of range, %0d full; peak element count %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], peak_count);
        if (mismatches == 0)
            $display("indexed_insert_erase_array_unit_test OK");
        else
            $display("indexed_insert_erase_array_unit_test NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("indexed_insert_erase_array_unit_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
src/iiea_pkg.sv
src/iiea_cell.sv
src/iiea_ctrl.sv
src/indexed_insert_erase_array_unit.sv
tb/sv/indexed_insert_erase_array_unit_test.sv
